// ===== rtl/snkr_pkg.sv =====
// Shared types and constants of the sorted node key router.
package snkr_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int CHILD_W  = 32;
   localparam int IDX_W    = 5;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;

   // Depth of the command queue and of the result queue
   localparam int CMD_Q_DEPTH = 2;
   localparam int RSP_Q_DEPTH = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT   = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_READ   = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Decoded command as it waits between front and back
   typedef struct packed {
      logic               is_init;
      logic               is_lookup;
      logic               is_insert;
      logic               is_read;
      logic [KEY_W-1:0]   key;
      logic [CHILD_W-1:0] child;
      logic [IDX_W-1:0]   index;
   } op_type;

   // One result transaction
   typedef struct packed {
      logic [CHILD_W-1:0] found_child;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   key_count;
      status_type         status;
   } rsp_type;

endpackage

// ===== rtl/snkr_fifo.sv =====
// Small first-in first-out queue of fixed-width words.
module snkr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/snkr_front.sv =====
// Front end: accepts request transactions, decodes them and queues them.
module snkr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [snkr_pkg::CMD_W-1:0]   req_command,
   input  logic [snkr_pkg::KEY_W-1:0]   req_search_key,
   input  logic [snkr_pkg::CHILD_W-1:0] req_child_id,
   input  logic [snkr_pkg::IDX_W-1:0]   req_child_index,
   input  logic                         push,
   output logic                         full,
   output snkr_pkg::op_type             op,
   output logic                         op_valid,
   input  logic                         op_take
);
   import snkr_pkg::*;

   op_type                  dec_op;
   logic [$bits(op_type)-1:0] q_out;
   logic                    q_empty;

   // Command decode
   always_comb begin
      dec_op.is_init   = 1'b0;
      dec_op.is_lookup = 1'b0;
      dec_op.is_insert = 1'b0;
      dec_op.is_read   = 1'b0;
      dec_op.key       = req_search_key;
      dec_op.child     = req_child_id;
      dec_op.index     = req_child_index;
      case (command_type'(req_command))
         CMD_INIT:   dec_op.is_init   = 1'b1;
         CMD_LOOKUP: dec_op.is_lookup = 1'b1;
         CMD_INSERT: dec_op.is_insert = 1'b1;
         CMD_READ:   dec_op.is_read   = 1'b1;
         default:    dec_op.is_read   = 1'b1;
      endcase
   end

   // Command queue toward the node
   snkr_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (CMD_Q_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (dec_op),
      .full      (full),
      .pop       (op_take),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign op       = op_type'(q_out);
   assign op_valid = !q_empty;

endmodule

// ===== rtl/snkr_back.sv =====
// Back end: key/child cells, search, shift-insert; one op per cycle on rsp_space.
module snkr_back #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  snkr_pkg::op_type  op,
   input  logic              op_valid,
   output logic              op_take,
   input  logic              rsp_space,
   output snkr_pkg::rsp_type rsp,
   output logic              rsp_valid
);
   import snkr_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);

   logic [KEY_W-1:0]   keys_ff     [SLOTS];
   logic [KEY_W-1:0]   keys_in     [SLOTS];
   logic [CHILD_W-1:0] children_ff [SLOTS+1];
   logic [CHILD_W-1:0] children_in [SLOTS+1];
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [SLOTS-1:0]   le_key;
   logic [CNT_W-1:0]   pos;
   logic [CNT_W-1:0]   rd_addr;
   logic [CHILD_W-1:0] child_rd;
   logic [31:0]        idx_wide, pos_wide, cnt_wide;
   logic               node_full, range_bad, fire;

   assign fire      = op_valid && rsp_space;
   assign op_take   = fire;
   assign rsp_valid = fire;

   // Compare cells: stored key at or below the search key
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         le_key[i] = (CNT_W'(i) < count_ff) && (keys_ff[i] <= op.key);
      end
   end

   // Upper bound: first cell that is not at or below the key
   always_comb begin
      pos = CNT_W'(SLOTS);
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!le_key[i]) begin
            pos = CNT_W'(i);
         end
      end
   end

   assign node_full = (count_ff == CNT_W'(SLOTS));
   assign idx_wide  = 32'(op.index);
   assign pos_wide  = 32'(pos);
   assign range_bad = idx_wide > 32'(count_ff);
   assign rd_addr   = op.is_read ? idx_wide[CNT_W-1:0] : pos;
   assign child_rd  = children_ff[rd_addr];

   // Next node contents
   always_comb begin
      keys_in     = keys_ff;
      children_in = children_ff;
      count_in    = count_ff;
      if (fire && op.is_init) begin
         count_in       = '0;
         children_in[0] = op.child;
      end else if (fire && op.is_insert && !node_full) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (32'(i) == pos_wide) begin
               keys_in[i] = op.key;
            end else if (32'(i) > pos_wide) begin
               if (i > 0) begin
                  keys_in[i] = keys_ff[i-1];
               end
            end
         end
         for (int i = 0; i <= SLOTS; i++) begin
            if (32'(i) == pos_wide + 32'd1) begin
               children_in[i] = op.child;
            end else if (32'(i) > pos_wide + 32'd1) begin
               if (i > 0) begin
                  children_in[i] = children_ff[i-1];
               end
            end
         end
         count_in = count_ff + 1'b1;
      end
   end

   assign cnt_wide = 32'(count_in);

   // Result transaction
   always_comb begin
      rsp.found_child = '0;
      rsp.position    = '0;
      rsp.key_count   = cnt_wide[POS_W-1:0];
      rsp.status      = STATUS_OK;
      if (op.is_lookup) begin
         rsp.found_child = child_rd;
         rsp.position    = pos_wide[POS_W-1:0];
      end else if (op.is_insert) begin
         rsp.position = pos_wide[POS_W-1:0];
         if (node_full) begin
            rsp.status = STATUS_FULL;
         end
      end else if (op.is_read) begin
         if (range_bad) begin
            rsp.status = STATUS_RANGE;
         end else begin
            rsp.found_child = child_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Key and child cells, no reset
   always_ff @(posedge clock) begin
      keys_ff     <= keys_in;
      children_ff <= children_in;
   end

endmodule

// ===== rtl/sorted_node_key_router_top.sv =====
// Top level of the sorted node key router (one B+ tree internal node).
//
// Request side is a queue: drive req_* with push high; the transaction is
// taken at a clock edge where full is low. Commands: init node, lookup key,
// insert key and child, read child at index.
// Result side is a queue too: while empty is low the oldest result is on
// rsp_*; it is taken at a clock edge where pop is high.
// A taken request waits in the command queue until the result queue has
// space; then the node cells update and the result enters the result queue
// at the same edge. The node takes one transaction per cycle while the
// result queue has space: its compare cells find the upper-bound position
// and the key and child cells shift at the edge where the op is taken.
// When the receiver stalls, up to two results wait in the result queue and
// two more commands in the command queue; then full rises.
// Reset clears the key count and both queues; key and child storage holds
// no defined value until written, so an init should come first.
module sorted_node_key_router_top #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [snkr_pkg::CMD_W-1:0]    req_command,
   input  logic [snkr_pkg::KEY_W-1:0]    req_search_key,
   input  logic [snkr_pkg::CHILD_W-1:0]  req_child_id,
   input  logic [snkr_pkg::IDX_W-1:0]    req_child_index,
   input  logic                          push,
   output logic                          full,
   output logic [snkr_pkg::CHILD_W-1:0]  rsp_found_child,
   output logic [snkr_pkg::POS_W-1:0]    rsp_position,
   output logic [snkr_pkg::POS_W-1:0]    rsp_key_count,
   output logic [snkr_pkg::STATUS_W-1:0] rsp_status,
   output logic                          empty,
   input  logic                          pop
);
   import snkr_pkg::*;

   op_type                     op;
   logic                       op_valid;
   logic                       op_take;
   rsp_type                    rsp;
   logic                       rsp_valid;
   logic                       rsp_q_full;
   logic [$bits(rsp_type)-1:0] rsp_q_out;
   rsp_type                    rsp_head;

   // Accept and decode
   snkr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_search_key  (req_search_key),
      .req_child_id    (req_child_id),
      .req_child_index (req_child_index),
      .push            (push),
      .full            (full),
      .op              (op),
      .op_valid        (op_valid),
      .op_take         (op_take)
   );

   // Node cells and execution
   snkr_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .op_valid  (op_valid),
      .op_take   (op_take),
      .rsp_space (!rsp_q_full),
      .rsp       (rsp),
      .rsp_valid (rsp_valid)
   );

   // Result queue
   snkr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_valid),
      .push_data (rsp),
      .full      (rsp_q_full),
      .pop       (pop),
      .pop_data  (rsp_q_out),
      .empty     (empty)
   );

   assign rsp_head        = rsp_type'(rsp_q_out);
   assign rsp_found_child = rsp_head.found_child;
   assign rsp_position    = rsp_head.position;
   assign rsp_key_count   = rsp_head.key_count;
   assign rsp_status      = rsp_head.status;

endmodule
